[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Every module that asserts has ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/cst_pkg.sv]
package cst_pkg;

   // Number of byte slots in each character class register
   localparam int CLASS_CHARS = 8;
   localparam int CLASS_CNT_W = 4;

   // Characters with fixed meaning
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_NL    = 8'h0A;

   // Configuration register indexes
   localparam logic [1:0] CSR_SEPARATOR_CHARS = 2'd0;
   localparam logic [1:0] CSR_SEPARATOR_COUNT = 2'd1;
   localparam logic [1:0] CSR_DELIMITER_CHARS = 2'd2;
   localparam logic [1:0] CSR_DELIMITER_COUNT = 2'd3;

   // Up to three output words come from one text byte
   localparam int MAX_WORDS = 3;
   localparam int WORD_CNT_W = 2;

   // Bundle queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] token_byte;
      logic       token_end;
   } word_type;

   // All words caused by one text byte
   typedef struct packed {
      logic [WORD_CNT_W-1:0]      count;
      word_type [MAX_WORDS-1:0]   words;
   } bundle_type;

   // Queue status seen by its neighbors
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

[hdl/cst_front.sv]
`include "assert_macros.svh"

module cst_front import cst_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_end_of_text,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [63:0]            csr_wdata,
   input  queue_status_type       q_status,
   output logic                   q_push,
   output bundle_type             q_data
);

   typedef enum logic [2:0] {
      MODE_NORMAL     = 3'd0,
      MODE_SLASH      = 3'd1,
      MODE_LINE       = 3'd2,
      MODE_BLOCK      = 3'd3,
      MODE_BLOCK_STAR = 3'd4
   } mode_type;

   // Held token byte together with the words gathered so far
   typedef struct packed {
      logic       held_valid;
      logic [7:0] held_byte;
      bundle_type bundle;
   } scan_type;

   mode_type                 mode_ff, mode_in;
   logic [7:0]               held_byte_ff, held_byte_in;
   logic                     held_valid_ff, held_valid_in;
   logic [63:0]              sep_chars_ff, delim_chars_ff;
   logic [CLASS_CNT_W-1:0]   sep_count_ff, delim_count_ff;
   logic                     accept;
   logic                     b_sep, b_delim, slash_sep, slash_delim;
   scan_type                 scan;

   // Byte matches one of the first count slots (count saturates)
   function automatic logic in_list(input logic [7:0] b, input logic [63:0] chars,
                                    input logic [CLASS_CNT_W-1:0] count);
      logic [CLASS_CNT_W-1:0] lim;
      logic                   hit;
      lim = (count > CLASS_CNT_W'(CLASS_CHARS)) ? CLASS_CNT_W'(CLASS_CHARS) : count;
      hit = 1'b0;
      for (int i = 0; i < CLASS_CHARS; i++) begin
         if ((CLASS_CNT_W'(i) < lim) && (chars[8*i +: 8] == b))
            hit = 1'b1;
      end
      return hit;
   endfunction

   // Append a word unless the bundle is full
   function automatic bundle_type add_word(input bundle_type bd, input logic [7:0] b,
                                           input logic e);
      bundle_type r;
      r = bd;
      if (bd.count < WORD_CNT_W'(MAX_WORDS)) begin
         r.words[bd.count].token_byte = b;
         r.words[bd.count].token_end  = e;
         r.count = bd.count + WORD_CNT_W'(1);
      end
      return r;
   endfunction

   // Separator closes the token, delimiter closes it and stands alone,
   // anything else extends it
   function automatic scan_type classify(input scan_type s, input logic [7:0] b,
                                         input logic sep, input logic delim);
      scan_type r;
      r = s;
      if (sep) begin
         if (s.held_valid)
            r.bundle = add_word(r.bundle, s.held_byte, 1'b1);
         r.held_valid = 1'b0;
      end else if (delim) begin
         if (s.held_valid)
            r.bundle = add_word(r.bundle, s.held_byte, 1'b1);
         r.held_valid = 1'b0;
         r.bundle = add_word(r.bundle, b, 1'b1);
      end else begin
         if (s.held_valid)
            r.bundle = add_word(r.bundle, s.held_byte, 1'b0);
         r.held_byte  = b;
         r.held_valid = 1'b1;
      end
      return r;
   endfunction

   // Class lookups
   assign b_sep       = in_list(req_text_byte, sep_chars_ff, sep_count_ff);
   assign b_delim     = in_list(req_text_byte, delim_chars_ff, delim_count_ff);
   assign slash_sep   = in_list(CH_SLASH, sep_chars_ff, sep_count_ff);
   assign slash_delim = in_list(CH_SLASH, delim_chars_ff, delim_count_ff);

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   // Comment scanner and classification of one byte
   always_comb begin
      scan.held_valid   = held_valid_ff;
      scan.held_byte    = held_byte_ff;
      scan.bundle       = '0;
      mode_in           = mode_ff;
      unique case (mode_ff)
         MODE_SLASH: begin
            if (req_text_byte == CH_SLASH) begin
               mode_in = MODE_LINE;
            end else if (req_text_byte == CH_STAR) begin
               mode_in = MODE_BLOCK;
            end else begin
               mode_in = MODE_NORMAL;
               scan = classify(scan, CH_SLASH, slash_sep, slash_delim);
               scan = classify(scan, req_text_byte, b_sep, b_delim);
            end
         end
         MODE_LINE: begin
            if (req_text_byte == CH_NL) begin
               mode_in = MODE_NORMAL;
               scan = classify(scan, req_text_byte, b_sep, b_delim);
            end
         end
         MODE_BLOCK: begin
            if (req_text_byte == CH_STAR)
               mode_in = MODE_BLOCK_STAR;
         end
         MODE_BLOCK_STAR: begin
            if (req_text_byte == CH_SLASH)
               mode_in = MODE_NORMAL;
            else if (req_text_byte != CH_STAR)
               mode_in = MODE_BLOCK;
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (req_text_byte == CH_SLASH)
               mode_in = MODE_SLASH;
            else
               scan = classify(scan, req_text_byte, b_sep, b_delim);
         end
      endcase

      // End of text flushes a pending slash and the held byte
      if (req_end_of_text) begin
         if (mode_in == MODE_SLASH)
            scan = classify(scan, CH_SLASH, slash_sep, slash_delim);
         if (scan.held_valid)
            scan.bundle = add_word(scan.bundle, scan.held_byte, 1'b1);
         mode_in         = MODE_NORMAL;
         scan.held_byte  = 8'd0;
         scan.held_valid = 1'b0;
      end

      held_byte_in  = scan.held_byte;
      held_valid_in = scan.held_valid;
   end

   // Only words are queued; bytes with no output leave nothing behind
   assign q_push = accept && (scan.bundle.count != '0);
   assign q_data = scan.bundle;

   // Scanner state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_NORMAL;
         held_byte_ff   <= 8'd0;
         held_valid_ff  <= 1'b0;
         sep_chars_ff   <= '0;
         sep_count_ff   <= '0;
         delim_chars_ff <= '0;
         delim_count_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            held_byte_ff  <= held_byte_in;
            held_valid_ff <= held_valid_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_SEPARATOR_CHARS: sep_chars_ff   <= csr_wdata;
               CSR_SEPARATOR_COUNT: sep_count_ff   <= csr_wdata[CLASS_CNT_W-1:0];
               CSR_DELIMITER_CHARS: delim_chars_ff <= csr_wdata;
               CSR_DELIMITER_COUNT: delim_count_ff <= csr_wdata[CLASS_CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Last byte of the text always leaves the scanner clean
   `ASSERT_NEXT(a_eot_clears, accept && req_end_of_text, !held_valid_ff && mode_ff == MODE_NORMAL, "scanner not cleared after end of text")

endmodule

[hdl/cst_queue.sv]
`include "assert_macros.svh"

module cst_queue import cst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bundle_type       push_data,
   input  logic             pop,
   output bundle_type       head,
   output queue_status_type status
);

   bundle_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic                     do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign head         = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   // Storage
   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         if (do_pop)
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         if (do_push && !do_pop)
            count_ff <= count_ff + QUEUE_CNT_W'(1);
         else if (do_pop && !do_push)
            count_ff <= count_ff - QUEUE_CNT_W'(1);
      end
   end

   `ASSERT_ALWAYS(a_count_range, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
   `ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_ff == $past(count_ff) + QUEUE_CNT_W'(1), "queue count did not grow on push")

endmodule

[hdl/cst_back.sv]
`include "assert_macros.svh"

module cst_back import cst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       q_head,
   input  queue_status_type q_status,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_token_byte,
   output logic             rsp_token_end,
   output logic             rsp_run_last
);

   bundle_type              cur_ff, cur_in;
   logic [WORD_CNT_W-1:0]   idx_ff, idx_in;
   logic                    busy_ff, busy_in;
   logic                    last, take;

   // Current word of the bundle in service
   assign last           = (idx_ff == cur_ff.count - WORD_CNT_W'(1));
   assign rsp_empty      = !busy_ff;
   assign rsp_token_byte = cur_ff.words[idx_ff].token_byte;
   assign rsp_token_end  = cur_ff.words[idx_ff].token_end;
   assign rsp_run_last   = last;

   assign take  = rsp_pop && busy_ff;
   assign q_pop = q_status.valid && (!busy_ff || (take && last));

   // Next bundle loads as the last word of this one leaves
   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (q_pop) begin
         cur_in  = q_head;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (take) begin
         if (last)
            busy_in = 1'b0;
         else
            idx_in = idx_ff + WORD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

   `ASSERT_ALWAYS(a_idx_in_bundle, !busy_ff || (idx_ff < cur_ff.count), "word index past bundle")
   `ASSERT_NEXT(a_idx_steps, take && !last, busy_ff && idx_ff == $past(idx_ff) + WORD_CNT_W'(1), "word index did not advance")

endmodule

[hdl/comment_stripping_tokenizer.sv]
// Streaming tokenizer with C comment removal. One text byte is accepted per
// clock while req_full is low; the front scanner resolves comments and byte
// classes in that cycle and writes the zero to three token words it causes into
// a four-entry bundle queue. The back end hands out one token word per clock on
// the rsp_ side while rsp_pop is high and rsp_empty is low. The first word of a
// byte is registered in a queue entry and then in cur_ff before it appears. The
// newest token byte and a lone '/' are held until a later byte settles them, and
// end_of_text flushes both. The user must write separator and delimiter lists
// through csr_ only while the block is idle; the block does not enforce this.
module comment_stripping_tokenizer import cst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic [7:0]   req_text_byte,
   input  logic         req_end_of_text,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [7:0]   rsp_token_byte,
   output logic         rsp_token_end,
   output logic         rsp_run_last,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   queue_status_type q_status;
   bundle_type       q_in_data, q_head;
   logic             q_push, q_pop;

   // Scanner and classifier
   cst_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_data          (q_in_data)
   );

   // Word bundles waiting for output
   cst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   // One word per clock to the consumer while it pops and words are waiting
   cst_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_token_byte (rsp_token_byte),
      .rsp_token_end  (rsp_token_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule
